### rtl/aicr_pkg.sv
// ----------------------------------------------------------------------------
// AABB impulse collision resolve package
// Shared widths, codes, and stage records for the collision response pipeline.
// ----------------------------------------------------------------------------
package aicr_pkg;

	localparam int unsigned COEF_W      = 15;
	localparam int unsigned DIV_STAGES  = 18;
	localparam int unsigned ONE_Q14     = 16384;
	localparam int unsigned SMALL_TANGENT = 2073;
	localparam int unsigned IN_DATA_W   = 248;
	localparam int unsigned OUT_DATA_W  = 160;

	typedef enum logic [1:0] {
		OUT_NONE     = 2'd0,
		OUT_SEPARATE = 2'd1,
		OUT_REST     = 2'd2,
		OUT_IMPULSE  = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		REG_RESTITUTION = 2'd0,
		REG_STATIC_MU   = 2'd1,
		REG_DYNAMIC_MU  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
	} vel_t;

	typedef struct packed {
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic [11:0]        a_width;
		logic [11:0]        a_height;
		logic [11:0]        b_width;
		logic [11:0]        b_height;
		vel_t               vel;
		logic [1:0]         movable_flags;
	} pair_t;

	typedef struct packed {
		vel_t               vel;
		outcome_t           outcome;
		logic signed [28:0] shift;
		logic               degen;
		logic               apply;
		logic               xaxis;
		logic               sneg;
		logic signed [49:0] qp;
		logic [48:0]        r1;
		logic [23:0]        rt2;
		logic [32:0]        art;
		logic               rtneg;
		logic               rt_small;
		logic [23:0]        sa;
		logic [24:0]        den;
	} front_t;

	typedef struct packed {
		vel_t               vel;
		outcome_t           outcome;
		logic signed [28:0] shift;
		logic               degen;
		logic               apply;
		logic               xaxis;
		logic [33:0]        qmag;
		logic               qneg;
		logic [35:0]        xmag;
		logic               xneg;
		logic               post;
	} meta_t;

endpackage

### rtl/aicr_front.sv
// ----------------------------------------------------------------------------
// AABB impulse collision resolve front end
// Overlap, contact axis, relative velocity, classification, first products.
// ----------------------------------------------------------------------------
module aicr_front import aicr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  pair_t             pair,
	input  logic [COEF_W-1:0] restitution,
	output logic              out_valid,
	output front_t            front
);

	logic              v_s1, v_s2, v_s3;
	logic signed [32:0] xo_s1, yo_s1, rvx_s1, rvy_s1;
	logic [23:0]       ma_s1, mb_s1;
	logic              sx_s1, sy_s1;
	logic [1:0]        fl_s1;
	vel_t              vel_s1;

	logic              contact_s2, xaxis_s2, ylt_s2, spos_s2, rtneg_s2, small_s2;
	logic              fa_s2, fb_s2, fl0_s2;
	logic signed [32:0] rn_s2, vn_s2;
	logic [32:0]       art_s2;
	logic [23:0]       sa_s2;
	logic [24:0]       den_s2;
	logic [28:0]       yo_s2;
	vel_t              vel_s2;

	front_t            f_s3;

	logic [11:0]       hx, hy;
	logic [31:0]       abs_ox, abs_oy;
	logic signed [32:0] xo, yo;
	logic              xaxis, spos, fa, fb;
	logic signed [32:0] rn, rt, vn;
	logic [32:0]       art;
	logic              vnpos, vnslow;
	outcome_t          outcome;
	logic [15:0]       e1;
	logic [32:0]       nvn;

	always_comb begin
		hx = 12'({1'b0, pair.a_width[11:1]}) + 12'({1'b0, pair.b_width[11:1]});
		hy = 12'({1'b0, pair.a_height[11:1]}) + 12'({1'b0, pair.b_height[11:1]});
		abs_ox = pair.offset_x[31] ? (~pair.offset_x + 32'd1) : pair.offset_x;
		abs_oy = pair.offset_y[31] ? (~pair.offset_y + 32'd1) : pair.offset_y;
		xo = $signed({5'b0, hx, 16'b0}) - $signed({1'b0, abs_ox});
		yo = $signed({5'b0, hy, 16'b0}) - $signed({1'b0, abs_oy});
	end

	always_comb begin
		xaxis = xo_s1 < yo_s1;
		rn = xaxis ? rvx_s1 : rvy_s1;
		rt = xaxis ? rvy_s1 : rvx_s1;
		spos = xaxis ? sx_s1 : sy_s1;
		vn = spos ? rn : -rn;
		art = rt[32] ? 33'(-rt) : 33'(rt);
		fa = fl_s1[0] && (ma_s1 != 24'd0);
		fb = fl_s1[1] && (mb_s1 != 24'd0);
	end

	always_comb begin
		vnpos = !vn_s2[32] && (vn_s2 != 33'sd0);
		vnslow = vn_s2 > -33'sd65536;
		if (!contact_s2) begin
			outcome = OUT_NONE;
		end else if (vnpos) begin
			outcome = OUT_SEPARATE;
		end else if (vnslow && ylt_s2) begin
			outcome = OUT_REST;
		end else begin
			outcome = OUT_IMPULSE;
		end
		e1 = 16'(ONE_Q14) + 16'(restitution);
		nvn = 33'(-vn_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xo_s1  <= xo;
			yo_s1  <= yo;
			rvx_s1 <= 33'(pair.vel.bx) - 33'(pair.vel.ax);
			rvy_s1 <= 33'(pair.vel.by) - 33'(pair.vel.ay);
			ma_s1  <= 24'(pair.a_width) * 24'(pair.a_height);
			mb_s1  <= 24'(pair.b_width) * 24'(pair.b_height);
			sx_s1  <= !pair.offset_x[31] && (pair.offset_x != 32'sd0);
			sy_s1  <= !pair.offset_y[31] && (pair.offset_y != 32'sd0);
			fl_s1  <= pair.movable_flags;
			vel_s1 <= pair.vel;

			contact_s2 <= !xo_s1[32] && !yo_s1[32];
			xaxis_s2   <= xaxis;
			ylt_s2     <= yo_s1 < xo_s1;
			spos_s2    <= spos;
			rn_s2      <= rn;
			vn_s2      <= vn;
			art_s2     <= art;
			rtneg_s2   <= rt[32];
			small_s2   <= art < 33'(SMALL_TANGENT);
			fa_s2      <= fa;
			fb_s2      <= fb;
			fl0_s2     <= fl_s1[0];
			sa_s2      <= (fa && fb) ? mb_s1 : {23'd0, fa};
			den_s2     <= (fa && fb) ? (25'(ma_s1) + 25'(mb_s1)) : 25'd1;
			yo_s2      <= yo_s1[28:0];
			vel_s2     <= vel_s1;

			f_s3.vel      <= vel_s2;
			f_s3.outcome  <= outcome;
			f_s3.shift    <= (outcome == OUT_REST && fl0_s2) ? 29'(-$signed(yo_s2)) : 29'sd0;
			f_s3.degen    <= (outcome == OUT_IMPULSE) && !fa_s2 && !fb_s2;
			f_s3.apply    <= (outcome == OUT_IMPULSE) && (fa_s2 || fb_s2);
			f_s3.xaxis    <= xaxis_s2;
			f_s3.sneg     <= !spos_s2;
			f_s3.qp       <= 50'($signed({1'b0, e1})) * 50'(rn_s2);
			f_s3.r1       <= 49'(e1) * 49'(nvn);
			f_s3.rt2      <= 24'(art_s2[11:0]) * 24'(art_s2[11:0]);
			f_s3.art      <= art_s2;
			f_s3.rtneg    <= rtneg_s2;
			f_s3.rt_small <= small_s2;
			f_s3.sa       <= sa_s2;
			f_s3.den      <= den_s2;
		end
	end

	assign out_valid = v_s3;
	assign front = f_s3;

endmodule

### rtl/aicr_coef.sv
// ----------------------------------------------------------------------------
// AABB impulse collision resolve coefficient stages
// Normal impulse, friction test and tangent term, and the dividend products.
// ----------------------------------------------------------------------------
module aicr_coef import aicr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  front_t            front,
	input  logic [COEF_W-1:0] static_mu,
	input  logic [COEF_W-1:0] dynamic_mu,
	output logic              out_valid,
	output meta_t             meta,
	output logic [59:0]       pq,
	output logic [59:0]       px,
	output logic [24:0]       den
);

	logic        v_s4, v_s5, v_s6, v_s7, v_s8;
	front_t      f_s4, f_s5, f_s6;
	logic [33:0] qmag_s4, qmag_s5, qmag_s6;
	logic        qneg_s4, qneg_s5, qneg_s6;
	logic [63:0] rhs_s4;
	logic [60:0] lhs_s4;
	logic [35:0] cmag_s4, cmag_s5, cmag_s6;
	logic        stat_s5, stat_s6;
	logic [48:0] dp_s5;
	logic [34:0] dmag_s6;
	logic [46:0] drp_s6;
	meta_t       m_s7, m_s8;
	logic [23:0] sa_s7;
	logic [24:0] den_s7, den_s8;
	logic [59:0] pq_s8, px_s8;

	logic [49:0] qabs;
	meta_t       m7;

	always_comb begin
		qabs = front.qp[49] ? 50'(-front.qp) : 50'(front.qp);
	end

	always_comb begin
		m7.vel     = f_s6.vel;
		m7.outcome = f_s6.outcome;
		m7.shift   = f_s6.shift;
		m7.degen   = f_s6.degen;
		m7.apply   = f_s6.apply;
		m7.xaxis   = f_s6.xaxis;
		m7.qmag    = qmag_s6;
		m7.qneg    = qneg_s6;
		if (stat_s6) begin
			m7.xmag = f_s6.rt_small ? cmag_s6 : 36'(f_s6.art);
			m7.xneg = f_s6.rtneg;
			m7.post = f_s6.rt_small;
		end else begin
			m7.xmag = f_s6.rt_small ? 36'(drp_s6[46:16]) : 36'(dmag_s6);
			m7.xneg = !(qneg_s6 ^ f_s6.rtneg ^ f_s6.sneg);
			m7.post = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s4    <= front;
			qmag_s4 <= qabs[47:14];
			qneg_s4 <= front.qp[49];
			rhs_s4  <= 64'(front.r1) * 64'(static_mu);
			cmag_s4 <= 36'(front.rt2) * 36'(front.art[11:0]);
			lhs_s4  <= front.rt_small ? {25'd0, front.rt2, 12'd0} : {front.art, 28'd0};

			f_s5    <= f_s4;
			qmag_s5 <= qmag_s4;
			qneg_s5 <= qneg_s4;
			cmag_s5 <= cmag_s4;
			stat_s5 <= 64'(lhs_s4) < rhs_s4;
			dp_s5   <= 49'(qmag_s4) * 49'(dynamic_mu);

			f_s6    <= f_s5;
			qmag_s6 <= qmag_s5;
			qneg_s6 <= qneg_s5;
			cmag_s6 <= cmag_s5;
			stat_s6 <= stat_s5;
			dmag_s6 <= dp_s5[48:14];
			drp_s6  <= 47'(dp_s5[48:14]) * 47'(f_s5.art[11:0]);

			m_s7   <= m7;
			sa_s7  <= f_s6.sa;
			den_s7 <= f_s6.den;

			m_s8   <= m_s7;
			den_s8 <= den_s7;
			pq_s8  <= 60'(m_s7.qmag) * 60'(sa_s7);
			px_s8  <= 60'(m_s7.xmag) * 60'(sa_s7);
		end
	end

	assign out_valid = v_s8;
	assign meta = m_s8;
	assign pq = pq_s8;
	assign px = px_s8;
	assign den = den_s8;

endmodule

### rtl/aicr_div.sv
// ----------------------------------------------------------------------------
// AABB impulse collision resolve divider
// Two-lane pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module aicr_div import aicr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  meta_t       meta_in,
	input  logic [59:0] pq,
	input  logic [59:0] px,
	input  logic [24:0] den,
	output logic        out_valid,
	output meta_t       meta_out,
	output logic [35:0] qq,
	output logic        qq_rem,
	output logic [35:0] qx,
	output logic        qx_rem
);

	logic [DIV_STAGES-1:0] v_s;
	logic [60:0]           wq_s   [DIV_STAGES];
	logic [60:0]           wx_s   [DIV_STAGES];
	logic [24:0]           den_s  [DIV_STAGES];
	meta_t                 meta_s [DIV_STAGES];

	function automatic logic [60:0] div_step(input logic [60:0] w, input logic [24:0] d);
		logic [25:0] t;
		logic        ge;
		logic [25:0] r;
		t = w[60:35];
		ge = t >= {1'b0, d};
		r = ge ? (t - {1'b0, d}) : t;
		return {r[24:0], w[34:0], ge};
	endfunction

	function automatic logic [60:0] div_two(input logic [60:0] w, input logic [24:0] d);
		return div_step(div_step(w, d), d);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wq_s[0]   <= div_two({1'b0, pq}, den);
			wx_s[0]   <= div_two({1'b0, px}, den);
			den_s[0]  <= den;
			meta_s[0] <= meta_in;
			for (int i = 1; i < DIV_STAGES; i++) begin
				wq_s[i]   <= div_two(wq_s[i-1], den_s[i-1]);
				wx_s[i]   <= div_two(wx_s[i-1], den_s[i-1]);
				den_s[i]  <= den_s[i-1];
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign meta_out = meta_s[DIV_STAGES-1];
	assign qq = wq_s[DIV_STAGES-1][35:0];
	assign qq_rem = |wq_s[DIV_STAGES-1][60:36];
	assign qx = wx_s[DIV_STAGES-1][35:0];
	assign qx_rem = |wx_s[DIV_STAGES-1][60:36];

endmodule

### rtl/aicr_back.sv
// ----------------------------------------------------------------------------
// AABB impulse collision resolve back end
// Splits each impulse between the boxes, adds it, and saturates the result.
// ----------------------------------------------------------------------------
module aicr_back import aicr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  meta_t              meta,
	input  logic [35:0]        qq,
	input  logic               qq_rem,
	input  logic [35:0]        qx,
	input  logic               qx_rem,
	output logic               out_valid,
	output outcome_t           outcome,
	output vel_t               vel,
	output logic signed [28:0] a_shift_y,
	output logic               degenerate
);

	logic               v_f1, v_f2;
	meta_t              m_f1;
	logic signed [36:0] dan_f1, dbn_f1, dat_f1, dbt_f1;
	outcome_t           outcome_f2;
	vel_t               vel_f2;
	logic signed [28:0] shift_f2;
	logic               degen_f2;

	logic [35:0] an_mag, bn_mag, at_mag, bt_mag, bt_full;
	logic signed [36:0] da_x, db_x, da_y, db_y;

	function automatic logic signed [36:0] apply_sign(input logic [35:0] m, input logic neg);
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] v,
			input logic signed [36:0] d);
		logic signed [37:0] s;
		s = 38'(v) + 38'(d);
		if (s > 38'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (s < -38'sd2147483648) begin
			return 32'sh80000000;
		end
		return s[31:0];
	endfunction

	always_comb begin
		an_mag = qq;
		bn_mag = 36'(meta.qmag) - qq - 36'(qq_rem);
		bt_full = meta.xmag - qx - 36'(qx_rem);
		at_mag = meta.post ? (qx >> 32) : qx;
		bt_mag = meta.post ? (bt_full >> 32) : bt_full;
	end

	always_comb begin
		da_x = m_f1.xaxis ? dan_f1 : dat_f1;
		db_x = m_f1.xaxis ? dbn_f1 : dbt_f1;
		da_y = m_f1.xaxis ? dat_f1 : dan_f1;
		db_y = m_f1.xaxis ? dbt_f1 : dbn_f1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (en) begin
			v_f1 <= in_valid;
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_f1   <= meta;
			dan_f1 <= apply_sign(an_mag, meta.qneg);
			dbn_f1 <= apply_sign(bn_mag, !meta.qneg);
			dat_f1 <= apply_sign(at_mag, meta.xneg);
			dbt_f1 <= apply_sign(bt_mag, !meta.xneg);

			outcome_f2 <= m_f1.outcome;
			shift_f2   <= m_f1.shift;
			degen_f2   <= m_f1.degen;
			if (m_f1.apply) begin
				vel_f2.ax <= add_sat(m_f1.vel.ax, da_x);
				vel_f2.ay <= add_sat(m_f1.vel.ay, da_y);
				vel_f2.bx <= add_sat(m_f1.vel.bx, db_x);
				vel_f2.by <= add_sat(m_f1.vel.by, db_y);
			end else begin
				vel_f2 <= m_f1.vel;
			end
		end
	end

	assign out_valid = v_f2;
	assign outcome = outcome_f2;
	assign vel = vel_f2;
	assign a_shift_y = shift_f2;
	assign degenerate = degen_f2;

endmodule

### rtl/aabb_impulse_collision_resolve_top.sv
// ----------------------------------------------------------------------------
// AABB impulse collision resolve top level
// Collision response with restitution and friction for one box pair per item.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  box pair, 248 bits
//   m_axis    out        m_axis_tvalid / m_axis_tready  response, 160 bits
//   cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One pair is taken every cycle while the output is not stalled; its result
// is offered through 28 register stages, most of them the 18-stage divider
// that shares the impulse by mass.
// Reset clears the coefficient registers and all pipeline valid bits.
// When the output holds a result that is not taken, the whole pipeline
// stalls and s_axis_tready is low; no item is lost or repeated.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module aabb_impulse_collision_resolve_top import aicr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// offset_x, offset_y, a_width, a_height, b_width, b_height,
	// a_vel_x, a_vel_y, b_vel_x, b_vel_y, movable_flags, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// outcome, new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y,
	// a_shift_y, degenerate
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [COEF_W-1:0]     cfg_data
);

	logic [COEF_W-1:0] restitution_q, static_mu_q, dynamic_mu_q;
	logic              en;
	pair_t             pair;

	logic              front_valid, coef_valid, div_valid;
	front_t            front;
	meta_t             coef_meta, div_meta;
	logic [59:0]       pq, px;
	logic [24:0]       den;
	logic [35:0]       qq, qx;
	logic              qq_rem, qx_rem;

	outcome_t           outcome;
	vel_t               vel;
	logic signed [28:0] a_shift_y;
	logic               degenerate;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= '0;
			static_mu_q   <= '0;
			dynamic_mu_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_RESTITUTION: begin
					restitution_q <= cfg_data;
				end
				REG_STATIC_MU: begin
					static_mu_q <= cfg_data;
				end
				REG_DYNAMIC_MU: begin
					dynamic_mu_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		pair.offset_x      = $signed(s_axis_tdata[31:0]);
		pair.offset_y      = $signed(s_axis_tdata[63:32]);
		pair.a_width       = s_axis_tdata[75:64];
		pair.a_height      = s_axis_tdata[87:76];
		pair.b_width       = s_axis_tdata[99:88];
		pair.b_height      = s_axis_tdata[111:100];
		pair.vel.ax        = $signed(s_axis_tdata[143:112]);
		pair.vel.ay        = $signed(s_axis_tdata[175:144]);
		pair.vel.bx        = $signed(s_axis_tdata[207:176]);
		pair.vel.by        = $signed(s_axis_tdata[239:208]);
		pair.movable_flags = s_axis_tdata[241:240];
	end

	aicr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_axis_tvalid),
		.pair        (pair),
		.restitution (restitution_q),
		.out_valid   (front_valid),
		.front       (front)
	);

	aicr_coef u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (front_valid),
		.front      (front),
		.static_mu  (static_mu_q),
		.dynamic_mu (dynamic_mu_q),
		.out_valid  (coef_valid),
		.meta       (coef_meta),
		.pq         (pq),
		.px         (px),
		.den        (den)
	);

	aicr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (coef_valid),
		.meta_in   (coef_meta),
		.pq        (pq),
		.px        (px),
		.den       (den),
		.out_valid (div_valid),
		.meta_out  (div_meta),
		.qq        (qq),
		.qq_rem    (qq_rem),
		.qx        (qx),
		.qx_rem    (qx_rem)
	);

	aicr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (div_valid),
		.meta       (div_meta),
		.qq         (qq),
		.qq_rem     (qq_rem),
		.qx         (qx),
		.qx_rem     (qx_rem),
		.out_valid  (m_axis_tvalid),
		.outcome    (outcome),
		.vel        (vel),
		.a_shift_y  (a_shift_y),
		.degenerate (degenerate)
	);

	assign m_axis_tdata = {degenerate, a_shift_y, vel.by, vel.bx, vel.ay, vel.ax, outcome};

endmodule
